// ----- hdl/gsed_pkg.sv -----
// Package for the Gaussian + Sobel edge detector.
// Holds field widths, register reset values, register indexes and shared types.
// No dependencies.
package gsed_pkg;

    localparam int GSED_MAX_WIDTH  = 2048;
    localparam int GSED_PIX_W      = 8;
    localparam int GSED_ROW_W      = 17;
    localparam int GSED_IMG_W_W    = 12;
    localparam int GSED_IMG_H_W    = 16;
    localparam int GSED_THR_W      = 8;
    localparam int GSED_CFG_IDX_W  = 2;
    localparam int GSED_CFG_DATA_W = 16;

    localparam logic [GSED_IMG_W_W-1:0] GSED_RST_WIDTH  = 12'd640;
    localparam logic [GSED_IMG_H_W-1:0] GSED_RST_HEIGHT = 16'd480;
    localparam logic [GSED_THR_W-1:0]   GSED_RST_THRESH = 8'd150;

    typedef enum logic [GSED_CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2
    } t_cfg_idx;

    // 3x3 window, row major, top row first
    typedef logic [8:0][GSED_PIX_W-1:0] t_win;

    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [GSED_ROW_W-1:0] row;
    } t_stage_ctl;

endpackage

// ----- hdl/gsed_if.sv -----
// Channel interfaces of the edge detector: pixel requests, results, config writes.
// Depends on gsed_pkg.
interface gsed_pix_if;
    import gsed_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [GSED_PIX_W-1:0] pixel_value;
    logic                  drain;
    modport source (output valid, output pixel_value, output drain, input ready);
    modport sink   (input valid, input pixel_value, input drain, output ready);
endinterface

interface gsed_res_if;
    logic valid;
    logic ready;
    logic edge_res;
    logic frame_end;
    modport source (output valid, output edge_res, output frame_end, input ready);
    modport sink   (input valid, input edge_res, input frame_end, output ready);
endinterface

interface gsed_cfg_if;
    import gsed_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [GSED_CFG_IDX_W-1:0]  index;
    logic [GSED_CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/gsed_win_stage.sv -----
// 3x3 window stage: two-row line store in one RAM, read bypass and the window registers.
// Depends on gsed_pkg.
module gsed_win_stage #(
    parameter int  MAX_WIDTH = gsed_pkg::GSED_MAX_WIDTH,
    localparam int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_clr,
    input  gsed_pkg::t_stage_ctl              i_ctl,
    input  logic [CW-1:0]                     i_col,
    input  logic [gsed_pkg::GSED_PIX_W-1:0]   i_px,
    output gsed_pkg::t_stage_ctl              o_ctl,
    output logic [CW-1:0]                     o_col,
    output gsed_pkg::t_win                    o_nb
);
    import gsed_pkg::*;

    localparam int LW = 2 * GSED_PIX_W;

    // upper byte: row two back, lower byte: previous row
    logic [LW-1:0] mem [MAX_WIDTH];

    t_stage_ctl                r_ctl;
    logic [CW-1:0]             r_col;
    logic [GSED_PIX_W-1:0]     r_px;
    logic [LW-1:0]             r_rd;
    logic [LW-1:0]             r_byp_d;
    logic                      r_byp;
    t_win                      r_win;
    t_win                      n_win;
    t_win                      nb;
    logic [LW-1:0]             rd;
    logic [LW-1:0]             wr_data;
    logic                      wr_en;
    logic [2:0][GSED_PIX_W-1:0] v;
    logic                      crow_ok;
    logic [GSED_ROW_W-1:0]     crow;

    always_comb begin
        rd      = r_byp ? r_byp_d : r_rd;
        wr_en   = i_adv && r_ctl.valid;
        wr_data = {rd[GSED_PIX_W-1:0], r_px};
        v[0]    = (r_ctl.row >= GSED_ROW_W'(2)) ? rd[LW-1:GSED_PIX_W] : '0;
        v[1]    = (r_ctl.row >= GSED_ROW_W'(1)) ? rd[GSED_PIX_W-1:0] : '0;
        v[2]    = r_px;
        if (r_col == '0) begin
            // row wrap: finish the last centre of the previous row, pad right
            for (int k = 0; k < 3; k++) begin
                nb[3*k]      = r_win[3*k+1];
                nb[3*k+1]    = r_win[3*k+2];
                nb[3*k+2]    = '0;
                n_win[3*k]   = '0;
                n_win[3*k+1] = '0;
                n_win[3*k+2] = v[k];
            end
            crow_ok = (r_ctl.row >= GSED_ROW_W'(2));
            crow    = r_ctl.row - GSED_ROW_W'(2);
        end else begin
            for (int k = 0; k < 3; k++) begin
                n_win[3*k]   = r_win[3*k+1];
                n_win[3*k+1] = r_win[3*k+2];
                n_win[3*k+2] = v[k];
            end
            nb      = n_win;
            crow_ok = (r_ctl.row >= GSED_ROW_W'(1));
            crow    = r_ctl.row - GSED_ROW_W'(1);
        end
        o_ctl.valid = r_ctl.valid && crow_ok;
        o_ctl.last  = r_ctl.last;
        o_ctl.row   = crow;
        o_col       = r_col;
        o_nb        = nb;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd <= mem[i_col];
        end
        if (wr_en) begin
            mem[r_col] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
            r_byp <= 1'b0;
            r_win <= '0;
        end else begin
            if (i_adv) begin
                r_ctl <= i_ctl;
                r_byp <= wr_en && (r_col == i_col);
            end
            if (i_clr) begin
                r_win <= '0;
            end else if (wr_en) begin
                r_win <= r_ctl.last ? '0 : n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_col   <= i_col;
            r_px    <= i_px;
            r_byp_d <= wr_data;
        end
    end

endmodule

// ----- hdl/gaussian_sobel_edge_detect.sv -----
// Top level of the streaming 3x3 Gaussian blur + 3x3 Sobel edge detector.
// Depends on gsed_pkg, gsed_if.sv and gsed_win_stage.
//
// Takes one pixel or drain request per clock and gives one edge flag per pixel, in raster
// order. A request travels through five registers (window stage A, window stage B, gradient,
// square, result) before its flag reaches the output; in stream terms the flag for pixel e is
// produced by request e + 2W + 2, so 2W + 2 drain requests follow the last pixel of a frame.
// The rate is set by the line stores: each is one RAM of MAX_WIDTH entries, read and written
// once per request, so the block sustains one request per cycle. Drains before the last pixel
// of a frame are taken and dropped. Config writes are taken at any time, restart the frame and
// must only be sent while the block is idle. A zero width or height counts as 1; widths above
// MAX_WIDTH are clamped. The pipeline stalls as a whole only when a result waits and the sink
// is not ready.
module gaussian_sobel_edge_detect #(
    parameter int MAX_WIDTH = gsed_pkg::GSED_MAX_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gsed_pix_if.sink   i_pix,
    gsed_cfg_if.sink   i_cfg,
    gsed_res_if.source o_res
);
    import gsed_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WW > GSED_IMG_W_W) ? WW : GSED_IMG_W_W;
    localparam int LIM_W = 2 * (GSED_THR_W + 1);
    localparam int SQ_W  = 20;
    localparam int GS_W  = 12;

    // configuration
    logic [GSED_IMG_W_W-1:0] r_img_w;
    logic [GSED_IMG_H_W-1:0] r_img_h;
    logic [GSED_THR_W-1:0]   r_thr;
    logic [LIM_W-1:0]        r_lim;
    logic [GSED_THR_W:0]     thr1;
    logic                    cfg_wr;
    logic                    cfg_hit;

    // input position
    logic [CW-1:0]           r_in_col;
    logic [GSED_ROW_W-1:0]   r_in_row;

    logic [WW-1:0]           w_eff;
    logic [GSED_IMG_H_W-1:0] h_eff;
    logic [GSED_ROW_W-1:0]   h_ext;
    logic                    adv;
    logic                    accept;
    logic                    pixel_row;
    logic                    take;
    logic                    is_last;
    logic                    row_end;

    t_stage_ctl              a_in_ctl, a_out_ctl, b_in_ctl, b_out_ctl;
    logic [CW-1:0]           a_out_col, b_out_col, sc;
    logic [GSED_PIX_W-1:0]   a_px, b_px;
    t_win                    a_nb, b_nb;
    logic [GS_W-1:0]         gsum;
    logic [9:0]              gxp, gxn, gyp, gyn;
    logic signed [10:0]      gx, gy;

    logic                    r_s3_valid, r_s3_last;
    logic signed [10:0]      r_gx, r_gy;
    logic signed [21:0]      sqx_full, sqy_full;
    logic                    r_s4_valid, r_s4_last;
    logic [SQ_W-1:0]         r_sqx, r_sqy;
    logic [SQ_W:0]           mag;
    logic                    r_out_valid, r_out_edge, r_out_last;

    // effective frame size
    always_comb begin
        if (r_img_w == '0) begin
            w_eff = WW'(1);
        end else if (CMP_W'(r_img_w) > CMP_W'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_img_w);
        end
        h_eff = (r_img_h == '0) ? GSED_IMG_H_W'(1) : r_img_h;
        h_ext = GSED_ROW_W'(h_eff);
    end

    assign adv         = !r_out_valid || o_res.ready;
    assign i_pix.ready = adv;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_pix.valid && adv;
    assign pixel_row   = (r_in_row < h_ext);
    assign take        = accept && !(pixel_row && i_pix.drain);
    assign row_end     = ((CW+1)'(r_in_col) + (CW+1)'(1)) >= (CW+1)'(w_eff);
    // the request that completes the frame's last result
    assign is_last     = (w_eff == WW'(1)) ? (r_in_row == h_ext + GSED_ROW_W'(3))
                       : ((r_in_row == h_ext + GSED_ROW_W'(2)) && (r_in_col == CW'(1)));

    assign cfg_wr  = i_cfg.valid;
    always_comb begin
        case (t_cfg_idx'(i_cfg.index))
            CFG_IMAGE_WIDTH:    cfg_hit = 1'b1;
            CFG_IMAGE_HEIGHT:   cfg_hit = 1'b1;
            CFG_EDGE_THRESHOLD: cfg_hit = 1'b1;
            default:            cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= GSED_RST_WIDTH;
            r_img_h  <= GSED_RST_HEIGHT;
            r_thr    <= GSED_RST_THRESH;
            r_in_col <= '0;
            r_in_row <= '0;
        end else if (cfg_wr && cfg_hit) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_IMAGE_WIDTH:    r_img_w <= i_cfg.data[GSED_IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT:   r_img_h <= i_cfg.data[GSED_IMG_H_W-1:0];
                CFG_EDGE_THRESHOLD: r_thr   <= i_cfg.data[GSED_THR_W-1:0];
                default: begin
                end
            endcase
            r_in_col <= '0;
            r_in_row <= '0;
        end else if (take) begin
            if (is_last) begin
                r_in_col <= '0;
                r_in_row <= '0;
            end else if (row_end) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + GSED_ROW_W'(1);
            end else begin
                r_in_col <= r_in_col + CW'(1);
            end
        end
    end

    assign thr1 = {1'b0, r_thr} + (GSED_THR_W+1)'(1);
    always_ff @(posedge i_clk) begin
        r_lim <= LIM_W'(thr1) * LIM_W'(thr1);
    end

    // stage A: raw pixels
    always_comb begin
        a_in_ctl.valid = take;
        a_in_ctl.last  = is_last;
        a_in_ctl.row   = r_in_row;
        a_px           = pixel_row ? i_pix.pixel_value : '0;
    end

    gsed_win_stage #(.MAX_WIDTH(MAX_WIDTH)) u_stage_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_clr   (cfg_wr && cfg_hit),
        .i_ctl   (a_in_ctl),
        .i_col   (r_in_col),
        .i_px    (a_px),
        .o_ctl   (a_out_ctl),
        .o_col   (a_out_col),
        .o_nb    (a_nb)
    );

    // Gaussian 1 2 1 / 2 4 2 / 1 2 1, divide by 16
    always_comb begin
        gsum = GS_W'(a_nb[0]) + GS_W'({a_nb[1], 1'b0}) + GS_W'(a_nb[2])
             + GS_W'({a_nb[3], 1'b0}) + GS_W'({a_nb[4], 2'b00}) + GS_W'({a_nb[5], 1'b0})
             + GS_W'(a_nb[6]) + GS_W'({a_nb[7], 1'b0}) + GS_W'(a_nb[8]);
        sc   = (a_out_col == '0) ? CW'(w_eff - WW'(1)) : (a_out_col - CW'(1));
        b_in_ctl = a_out_ctl;
        b_px     = (a_out_ctl.row < h_ext) ? gsum[GS_W-1:4] : '0;
    end

    // stage B: smoothed pixels
    gsed_win_stage #(.MAX_WIDTH(MAX_WIDTH)) u_stage_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_clr   (cfg_wr && cfg_hit),
        .i_ctl   (b_in_ctl),
        .i_col   (sc),
        .i_px    (b_px),
        .o_ctl   (b_out_ctl),
        .o_col   (b_out_col),
        .o_nb    (b_nb)
    );

    // Sobel gradients
    always_comb begin
        gxp = 10'(b_nb[2]) + 10'({b_nb[5], 1'b0}) + 10'(b_nb[8]);
        gxn = 10'(b_nb[0]) + 10'({b_nb[3], 1'b0}) + 10'(b_nb[6]);
        gyp = 10'(b_nb[6]) + 10'({b_nb[7], 1'b0}) + 10'(b_nb[8]);
        gyn = 10'(b_nb[0]) + 10'({b_nb[1], 1'b0}) + 10'(b_nb[2]);
        gx  = $signed({1'b0, gxp}) - $signed({1'b0, gxn});
        gy  = $signed({1'b0, gyp}) - $signed({1'b0, gyn});
    end

    assign sqx_full = r_gx * r_gx;
    assign sqy_full = r_gy * r_gy;
    assign mag      = (SQ_W+1)'(r_sqx) + (SQ_W+1)'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid  <= b_out_ctl.valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_last  <= b_out_ctl.last;
            r_gx       <= gx;
            r_gy       <= gy;
            r_s4_last  <= r_s3_last;
            r_sqx      <= sqx_full[SQ_W-1:0];
            r_sqy      <= sqy_full[SQ_W-1:0];
            r_out_last <= r_s4_last;
            r_out_edge <= (mag >= (SQ_W+1)'(r_lim));
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.edge_res  = r_out_edge;
    assign o_res.frame_end = r_out_last;

endmodule

// ----- hdl/gsed_checker.sv -----
// Port-level checks for the edge detector, bound to the top level.
// Depends on gaussian_sobel_edge_detect and gsed_if.sv.
module gsed_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_pix_ready,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_res_edge,
    input logic i_res_last
);

    // sync reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // input side never blocked while no result waits
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_pix_ready)
        else $error("pixel request refused with empty output");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_edge) && $stable(i_res_last))
        else $error("result changed while stalled");

endmodule

bind gaussian_sobel_edge_detect gsed_checker u_gsed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_ready (i_pix.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_edge  (o_res.edge_res),
    .i_res_last  (o_res.frame_end)
);
